// ===== rtl/core/i2a_pkg.sv =====
`default_nettype none

package i2a_pkg;

    localparam int unsigned VALUE_W   = 32;
    localparam int unsigned DIGIT_W   = 4;
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned DIGITS_MAX = 10;
    localparam int unsigned CNT_W     = 4;
    localparam int unsigned PROD_W    = 2 * VALUE_W;

    // Reciprocal of ten, scaled by two to the power RECIP_SHIFT.
    localparam logic [VALUE_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP_SHIFT = 35;
    localparam int unsigned        QDEC_W      = PROD_W - RECIP_SHIFT;
    localparam int unsigned        HEX_SHIFT   = 4;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_ALPHA = 8'h41 - 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;
    localparam logic [DIGIT_W-1:0] DEC_BASE   = 4'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {{(CHAR_W-DIGIT_W){1'b0}}, d};
        if (d < DEC_BASE) begin
            return CHAR_ZERO + d_ext;
        end
        return CHAR_ALPHA + d_ext;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/i2a_div_unit.sv =====
`default_nettype none

module i2a_div_unit (
    input  wire logic                              i_clk,
    input  wire logic [i2a_pkg::VALUE_W-1:0]       i_x,
    input  wire logic                              i_hex,
    output logic      [i2a_pkg::VALUE_W-1:0]       o_quot,
    output logic      [i2a_pkg::DIGIT_W-1:0]       o_rem
);

    logic [i2a_pkg::PROD_W-1:0]   n_prod;
    logic [i2a_pkg::QDEC_W-1:0]   r_qdec;
    logic [i2a_pkg::VALUE_W-1:0]  r_x;
    logic                         r_hex;
    logic [i2a_pkg::VALUE_W-1:0]  quot_times_ten;
    logic [i2a_pkg::VALUE_W-1:0]  diff;

    assign n_prod = {{i2a_pkg::VALUE_W{1'b0}}, i_x}
                  * {{i2a_pkg::VALUE_W{1'b0}}, i2a_pkg::RECIP_TEN};

    always_ff @(posedge i_clk) begin
        r_qdec <= n_prod[i2a_pkg::PROD_W-1:i2a_pkg::RECIP_SHIFT];
        r_x    <= i_x;
        r_hex  <= i_hex;
    end

    always_comb begin
        if (r_hex) begin
            o_quot = r_x >> i2a_pkg::HEX_SHIFT;
        end else begin
            o_quot = {{(i2a_pkg::VALUE_W-i2a_pkg::QDEC_W){1'b0}}, r_qdec};
        end
        quot_times_ten = (o_quot << 3) + (o_quot << 1);
        diff           = r_x - quot_times_ten;
        if (r_hex) begin
            o_rem = r_x[i2a_pkg::DIGIT_W-1:0];
        end else begin
            o_rem = diff[i2a_pkg::DIGIT_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/int_to_ascii_radix_unit.sv =====
// The sequencer runs S_MUL and S_DIV per digit, then S_SIGN if negative, then S_EMIT.
// Each digit uses the shared divide unit (reciprocal multiply or hex shift, then remainder).
// Busy holds from an accepted start until the return to S_IDLE; start is taken only in S_IDLE.
// Characters leave one per cycle and the receiver cannot stall them.
// Synchronous active-low reset returns the sequencer to idle and clears the strobe.
`default_nettype none

module int_to_ascii_radix_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [i2a_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                          i_radix_select,
    output logic                               o_valid,
    output logic      [i2a_pkg::CHAR_W-1:0]    o_char_code,
    output logic                               o_last
);

    i2a_pkg::t_state                     r_state, n_state;
    logic [i2a_pkg::VALUE_W-1:0]         r_mag, n_mag;
    logic                                r_neg, n_neg;
    logic                                r_hex, n_hex;
    logic [i2a_pkg::CNT_W-1:0]           r_cnt, n_cnt;
    logic [i2a_pkg::DIGIT_W-1:0]         r_digits [i2a_pkg::DIGITS_MAX];
    logic                                dig_we;
    logic                                r_valid, n_valid;
    logic [i2a_pkg::CHAR_W-1:0]          r_char, n_char;
    logic                                r_last, n_last;
    logic [i2a_pkg::VALUE_W-1:0]         quot;
    logic [i2a_pkg::DIGIT_W-1:0]         rem;
    logic [i2a_pkg::CNT_W-1:0]           rd_idx;

    i2a_div_unit u_div (
        .i_clk  (i_clk),
        .i_x    (r_mag),
        .i_hex  (r_hex),
        .o_quot (quot),
        .o_rem  (rem)
    );

    assign busy        = (r_state != i2a_pkg::S_IDLE);
    assign o_valid     = r_valid;
    assign o_char_code = r_char;
    assign o_last      = r_last;
    assign rd_idx      = r_cnt - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i2a_pkg::S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_neg  <= n_neg;
        r_hex  <= n_hex;
        r_cnt  <= n_cnt;
        r_char <= n_char;
        r_last <= n_last;
        if (dig_we) begin
            r_digits[r_cnt] <= rem;
        end
    end

    always_comb begin
        n_state = r_state;
        n_mag   = r_mag;
        n_neg   = r_neg;
        n_hex   = r_hex;
        n_cnt   = r_cnt;
        n_valid = 1'b0;
        n_char  = r_char;
        n_last  = r_last;
        dig_we  = 1'b0;
        unique case (r_state)
            i2a_pkg::S_IDLE: begin
                if (start) begin
                    n_neg   = i_value[i2a_pkg::VALUE_W-1];
                    n_mag   = i_value[i2a_pkg::VALUE_W-1] ? (~i_value + 1'b1) : i_value;
                    n_hex   = i_radix_select;
                    n_cnt   = '0;
                    n_state = i2a_pkg::S_MUL;
                end
            end
            i2a_pkg::S_MUL: begin
                n_state = i2a_pkg::S_DIV;
            end
            i2a_pkg::S_DIV: begin
                dig_we = 1'b1;
                n_mag  = quot;
                n_cnt  = r_cnt + 1'b1;
                if ((quot == '0)
                        || (r_cnt == i2a_pkg::CNT_W'(i2a_pkg::DIGITS_MAX - 1))) begin
                    n_state = r_neg ? i2a_pkg::S_SIGN : i2a_pkg::S_EMIT;
                end else begin
                    n_state = i2a_pkg::S_MUL;
                end
            end
            i2a_pkg::S_SIGN: begin
                n_valid = 1'b1;
                n_char  = i2a_pkg::CHAR_MINUS;
                n_last  = 1'b0;
                n_state = i2a_pkg::S_EMIT;
            end
            i2a_pkg::S_EMIT: begin
                n_valid = 1'b1;
                n_char  = i2a_pkg::digit_char(r_digits[rd_idx]);
                n_last  = (r_cnt == i2a_pkg::CNT_W'(1));
                n_cnt   = rd_idx;
                if (r_cnt == i2a_pkg::CNT_W'(1)) begin
                    n_state = i2a_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = i2a_pkg::S_IDLE;
            end
        endcase
    end

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted word");

    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("character emitted straight after a final character");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> busy)
        else $error("non-final character while the sequencer is idle");

endmodule

`default_nettype wire
